### hw/rtl/rcpd_pkg.sv
// Shared types and constants of the RC pulse capture decoder.
package rcpd_pkg;

  localparam int NUM_CHANNELS = 8;   // stored channel widths, 4..8
  localparam int NUM_LINES    = 8;   // PWM input lines, set by the 3-bit index
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int FC_W         = $clog2(NUM_CHANNELS + 1);
  localparam int STAMP_W      = 16;
  localparam int IDX_W        = 3;
  localparam int GOOD_W       = 4;
  localparam int GOOD_CHANNELS = 4;
  localparam logic [GOOD_W-1:0] GOOD_ALL = 4'h0F;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic               PPM_MODE_RST  = 1'b1;
  localparam logic [STAMP_W-1:0] WIDTH_LO_RST  = 16'd750;
  localparam logic [STAMP_W-1:0] WIDTH_HI_RST  = 16'd2250;
  localparam logic [STAMP_W-1:0] SYNC_GAP_RST  = 16'd2700;
  localparam logic [STAMP_W-1:0] FS_THRESH_RST = 16'd985;

  typedef enum logic [2:0] {
    REG_PPM_MODE  = 3'd0,
    REG_WIDTH_LO  = 3'd1,
    REG_WIDTH_HI  = 3'd2,
    REG_SYNC_GAP  = 3'd3,
    REG_FS_THRESH = 3'd4
  } rcpd_reg_t;

  typedef struct packed {
    logic               ppm_mode;
    logic [STAMP_W-1:0] width_lo;
    logic [STAMP_W-1:0] width_hi;
    logic [STAMP_W-1:0] sync_gap;
    logic [STAMP_W-1:0] failsafe_threshold;
  } rcpd_cfg_t;

endpackage

### hw/rtl/rcpd_if.sv
// Valid/ready channel interfaces for requests and results.
interface rcpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [rcpd_pkg::IDX_W-1:0]    channel_index;
  logic [rcpd_pkg::STAMP_W-1:0]  capture_time;

  modport source (output valid, req_type, channel_index, capture_time, input ready);
  modport sink   (input valid, req_type, channel_index, capture_time, output ready);
endinterface

interface rcpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rcpd_pkg::STAMP_W-1:0]  width_value;
  logic                          width_updated;
  logic [rcpd_pkg::IDX_W-1:0]    updated_channel;
  logic                          next_edge_falling;
  logic                          failsafe_clear;

  modport source (output valid, width_value, width_updated, updated_channel,
                  next_edge_falling, failsafe_clear, input ready);
  modport sink   (input valid, width_value, width_updated, updated_channel,
                  next_edge_falling, failsafe_clear, output ready);
endinterface

### hw/rtl/rcpd_cfg.sv
// APB-style configuration register bank.
module rcpd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rcpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rcpd_pkg::rcpd_cfg_t             cfg
);

  rcpd_pkg::rcpd_cfg_t cfg_r;
  rcpd_pkg::rcpd_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = rcpd_pkg::rcpd_reg_t'(paddr[rcpd_pkg::CFG_ADDR_W-1:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppm_mode           <= rcpd_pkg::PPM_MODE_RST;
      cfg_r.width_lo           <= rcpd_pkg::WIDTH_LO_RST;
      cfg_r.width_hi           <= rcpd_pkg::WIDTH_HI_RST;
      cfg_r.sync_gap           <= rcpd_pkg::SYNC_GAP_RST;
      cfg_r.failsafe_threshold <= rcpd_pkg::FS_THRESH_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        rcpd_pkg::REG_PPM_MODE:  cfg_r.ppm_mode           <= pwdata[0];
        rcpd_pkg::REG_WIDTH_LO:  cfg_r.width_lo           <= pwdata[rcpd_pkg::STAMP_W-1:0];
        rcpd_pkg::REG_WIDTH_HI:  cfg_r.width_hi           <= pwdata[rcpd_pkg::STAMP_W-1:0];
        rcpd_pkg::REG_SYNC_GAP:  cfg_r.sync_gap           <= pwdata[rcpd_pkg::STAMP_W-1:0];
        rcpd_pkg::REG_FS_THRESH: cfg_r.failsafe_threshold <= pwdata[rcpd_pkg::STAMP_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rcpd_pkg::REG_PPM_MODE:  prdata = rcpd_pkg::CFG_DATA_W'(cfg_r.ppm_mode);
      rcpd_pkg::REG_WIDTH_LO:  prdata = rcpd_pkg::CFG_DATA_W'(cfg_r.width_lo);
      rcpd_pkg::REG_WIDTH_HI:  prdata = rcpd_pkg::CFG_DATA_W'(cfg_r.width_hi);
      rcpd_pkg::REG_SYNC_GAP:  prdata = rcpd_pkg::CFG_DATA_W'(cfg_r.sync_gap);
      rcpd_pkg::REG_FS_THRESH: prdata = rcpd_pkg::CFG_DATA_W'(cfg_r.failsafe_threshold);
      default:                 prdata = '0;
    endcase
  end

endmodule

### hw/rtl/rcpd_core.sv
// Decode datapath: input register, width/state logic, result register.
module rcpd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  rcpd_pkg::rcpd_cfg_t cfg,
  rcpd_in_if.sink             in_chan,
  rcpd_out_if.source          out_chan
);

  localparam int NCH = rcpd_pkg::NUM_CHANNELS;
  localparam int CHW = rcpd_pkg::CH_W;
  localparam int FCW = rcpd_pkg::FC_W;
  localparam int SW  = rcpd_pkg::STAMP_W;
  localparam int IW  = rcpd_pkg::IDX_W;
  localparam int GW  = rcpd_pkg::GOOD_W;

  // input stage
  logic          in_valid_r;
  logic          in_req_r;
  logic [IW-1:0] in_idx_r;
  logic [SW-1:0] in_stamp_r;

  // decoder state
  logic [SW-1:0]  last_stamp_r;
  logic [FCW-1:0] frame_channel_r;
  logic [SW-1:0]  channel_widths_r [NCH];
  logic [GW-1:0]  good_mask_r;
  logic [rcpd_pkg::NUM_LINES-1:0] awaiting_fall_r;
  logic [SW-1:0]  rise_stamps_r [rcpd_pkg::NUM_LINES];

  // result stage
  logic          out_valid_r;
  logic [SW-1:0] out_width_r;
  logic          out_upd_r;
  logic [IW-1:0] out_ch_r;
  logic          out_nfall_r;
  logic          out_fs_r;

  logic advance;
  logic take;

  // combinational decode
  logic           is_read;
  logic           ppm;
  logic           fall_now;
  logic [SW-1:0]  gap;
  logic [SW-1:0]  pwm_w;
  logic [SW-1:0]  width;
  logic           width_ok;
  logic           is_sync;
  logic           fc_lt;
  logic           idx_lt;
  logic           store;
  logic [CHW-1:0] store_ch;
  logic [GW-1:0]  mask_set;
  logic           mask_full;
  logic [GW-1:0]  good_nxt;
  logic [FCW-1:0] frame_channel_nxt;
  logic [SW-1:0]  rd_width;
  logic [SW-1:0]  out_width_nxt;
  logic [IW-1:0]  out_ch_nxt;
  logic           out_nfall_nxt;
  logic           out_fs_nxt;

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    is_read  = (in_req_r == rcpd_pkg::REQ_READ);
    ppm      = cfg.ppm_mode;
    fall_now = awaiting_fall_r[in_idx_r];
    gap      = in_stamp_r - last_stamp_r;
    pwm_w    = in_stamp_r - rise_stamps_r[in_idx_r];
    width    = ppm ? gap : pwm_w;
    width_ok = (width > cfg.width_lo) && (width < cfg.width_hi);
    is_sync  = gap > cfg.sync_gap;
    fc_lt    = 32'(frame_channel_r) < NCH;
    idx_lt   = 32'(in_idx_r) < NCH;

    if (ppm) begin
      store    = !is_read && !is_sync && width_ok && fc_lt;
      store_ch = CHW'(frame_channel_r);
    end else begin
      store    = !is_read && fall_now && width_ok && idx_lt;
      store_ch = CHW'(in_idx_r);
    end

    // good mask only tracks channels 0..3
    mask_set = good_mask_r;
    if ((32'(store_ch) < rcpd_pkg::GOOD_CHANNELS) && (width > cfg.failsafe_threshold)) begin
      mask_set = good_mask_r | (GW'(1) << store_ch);
    end
    mask_full = (mask_set == rcpd_pkg::GOOD_ALL);
    good_nxt  = mask_full ? '0 : mask_set;

    if (is_sync) begin
      frame_channel_nxt = '0;
    end else if (fc_lt) begin
      frame_channel_nxt = frame_channel_r + FCW'(1);
    end else begin
      frame_channel_nxt = frame_channel_r;  // saturated until next sync
    end

    rd_width = idx_lt ? channel_widths_r[CHW'(in_idx_r)] : '0;

    if (is_read) begin
      out_width_nxt = rd_width;
    end else if (store) begin
      out_width_nxt = width;
    end else begin
      out_width_nxt = '0;
    end
    out_ch_nxt    = store ? (ppm ? IW'(frame_channel_r) : in_idx_r) : '0;
    out_nfall_nxt = !is_read && !ppm && !fall_now;
    out_fs_nxt    = store && mask_full;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (take) begin
      in_req_r   <= in_chan.req_type;
      in_idx_r   <= in_chan.channel_index;
      in_stamp_r <= in_chan.capture_time;
    end
  end

  // decoder state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r    <= '0;
      frame_channel_r <= '0;
      good_mask_r     <= '0;
      awaiting_fall_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        channel_widths_r[i] <= '0;
      end
    end else if (advance && !is_read) begin
      if (ppm) begin
        last_stamp_r    <= in_stamp_r;
        frame_channel_r <= frame_channel_nxt;
      end else begin
        awaiting_fall_r[in_idx_r] <= !fall_now;
      end
      if (store) begin
        channel_widths_r[store_ch] <= width;
        good_mask_r                <= good_nxt;
      end
    end
  end

  // rise stamps: read only after written, no reset
  always_ff @(posedge clk) begin
    if (advance && !is_read && !ppm && !fall_now) begin
      rise_stamps_r[in_idx_r] <= in_stamp_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_width_r <= out_width_nxt;
      out_upd_r   <= store;
      out_ch_r    <= out_ch_nxt;
      out_nfall_r <= out_nfall_nxt;
      out_fs_r    <= out_fs_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.width_value       = out_width_r;
  assign out_chan.width_updated     = out_upd_r;
  assign out_chan.updated_channel   = out_ch_r;
  assign out_chan.next_edge_falling = out_nfall_r;
  assign out_chan.failsafe_clear    = out_fs_r;

  a_mask_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    good_mask_r != rcpd_pkg::GOOD_ALL)
    else $error("good mask left full");

  a_frame_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frame_channel_r) <= NCH)
    else $error("frame channel beyond saturation");

  a_fs_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fs_r) |-> out_upd_r)
    else $error("failsafe clear without stored width");

  a_rise_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nfall_r) |-> !out_upd_r)
    else $error("rise capture stored a width");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_stamp_r)))
    else $error("stalled input stage lost its transaction");

endmodule

### hw/rtl/rc_pulse_capture_decoder.sv
// Top level of the RC pulse capture decoder: config bank plus decode core.
//
// Decodes RC receiver timing from 16-bit timer capture stamps. Each request
// transaction (a capture event or a width read) yields exactly one result
// transaction. In PPM mode (ppm_mode=1) captures are differenced modulo 2^16;
// a gap above sync_gap restarts the frame at channel 0, and a gap strictly
// inside (width_lo, width_hi) is stored for the current slot, which counts
// up to NUM_CHANNELS and stays there until the next sync. In PWM mode each
// line alternates rise/fall captures and the width is fall minus rise.
// Good widths (above failsafe_threshold) on channels 0..3 fill a mask; when
// all four are in, the mask clears and failsafe_clear is set.
// Rate: one transaction per clock, sustained while the result side is ready.
// A request is accepted into the input register, then the decode logic (the
// 16-bit stamp subtract, the window compares and a state write) loads the
// result register. A stall at the output holds the request in the input
// register. The result register decouples the sides, so a new request is
// taken while a result waits. Stored widths reset to zero at once; there
// is no clearing pass.
// Config registers (APB, 32-bit, byte address 4*i): 0 ppm_mode, 1 width_lo,
// 2 width_hi, 3 sync_gap, 4 failsafe_threshold. Write only while idle.
module rc_pulse_capture_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  rcpd_in_if.sink                         in_chan,
  rcpd_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rcpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  // live register values to the datapath
  rcpd_pkg::rcpd_cfg_t cfg;

  rcpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // single-pass decode: input reg -> logic -> result reg
  rcpd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
